// ----- hdl/ussd_pkg.sv -----
// shared types, tables and helper functions of the ussd payload to utf-8 decoder
`default_nettype none

package ussd_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [6:0]  EscSeptet = 7'h1B;
    localparam logic [15:0] Utf8Two   = 16'h0080;
    localparam logic [15:0] Utf8Three = 16'h0800;
    localparam logic [7:0]  DcsGsm7   = 8'h10;
    localparam logic [7:0]  DcsUcs2   = 8'h11;

    typedef enum logic [1:0] {
        MODE_GSM7    = 2'd0,
        MODE_UCS2    = 2'd1,
        MODE_UNKNOWN = 2'd2
    } t_mode;

    // value is a code point, or a byte to copy as is when raw is set
    typedef struct packed {
        logic [15:0] value;
        logic        raw;
        logic        last;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_push;

    localparam logic [9:0] BasicMap [128] = '{
        10'h040, 10'h0A3, 10'h024, 10'h0A5, 10'h0E8, 10'h0E9, 10'h0F9, 10'h0EC,
        10'h0F2, 10'h0C7, 10'h00A, 10'h0D8, 10'h0F8, 10'h00D, 10'h0C5, 10'h0E5,
        10'h394, 10'h05F, 10'h3A6, 10'h393, 10'h39B, 10'h3A9, 10'h3A0, 10'h3A8,
        10'h3A3, 10'h398, 10'h39E, 10'h000, 10'h0C6, 10'h0E6, 10'h0DF, 10'h0C9,
        10'h020, 10'h021, 10'h022, 10'h023, 10'h0A4, 10'h025, 10'h026, 10'h027,
        10'h028, 10'h029, 10'h02A, 10'h02B, 10'h02C, 10'h02D, 10'h02E, 10'h02F,
        10'h030, 10'h031, 10'h032, 10'h033, 10'h034, 10'h035, 10'h036, 10'h037,
        10'h038, 10'h039, 10'h03A, 10'h03B, 10'h03C, 10'h03D, 10'h03E, 10'h03F,
        10'h0A1, 10'h041, 10'h042, 10'h043, 10'h044, 10'h045, 10'h046, 10'h047,
        10'h048, 10'h049, 10'h04A, 10'h04B, 10'h04C, 10'h04D, 10'h04E, 10'h04F,
        10'h050, 10'h051, 10'h052, 10'h053, 10'h054, 10'h055, 10'h056, 10'h057,
        10'h058, 10'h059, 10'h05A, 10'h0C4, 10'h0D6, 10'h0D1, 10'h0DC, 10'h0A7,
        10'h0BF, 10'h061, 10'h062, 10'h063, 10'h064, 10'h065, 10'h066, 10'h067,
        10'h068, 10'h069, 10'h06A, 10'h06B, 10'h06C, 10'h06D, 10'h06E, 10'h06F,
        10'h070, 10'h071, 10'h072, 10'h073, 10'h074, 10'h075, 10'h076, 10'h077,
        10'h078, 10'h079, 10'h07A, 10'h0E4, 10'h0F6, 10'h0F1, 10'h0FC, 10'h0E0
    };

    function automatic logic [15:0] basic_map(input logic [6:0] c);
        basic_map = {6'd0, BasicMap[c]};
    endfunction

    function automatic logic [15:0] extend_map(input logic [6:0] c);
        logic [15:0] v;
        unique case (c)
            7'h0A:   v = 16'h000C;
            7'h14:   v = 16'h005E;
            7'h28:   v = 16'h007B;
            7'h29:   v = 16'h007D;
            7'h2F:   v = 16'h005C;
            7'h3C:   v = 16'h005B;
            7'h3D:   v = 16'h007E;
            7'h3E:   v = 16'h005D;
            7'h40:   v = 16'h007C;
            7'h65:   v = 16'h20AC;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic t_mode classify(input logic [7:0] dcs);
        t_mode m;
        m = MODE_UNKNOWN;
        unique case (dcs[7:4])
            4'h0, 4'h2, 4'h3: m = MODE_GSM7;
            4'h1: begin
                if (dcs == DcsGsm7) begin
                    m = MODE_GSM7;
                end else if (dcs == DcsUcs2) begin
                    m = MODE_UCS2;
                end
            end
            4'h4, 4'h5, 4'h6, 4'h7: begin
                if (!dcs[5]) begin
                    if (dcs[3:2] == 2'd0) begin
                        m = MODE_GSM7;
                    end else if (dcs[3:2] == 2'd2) begin
                        m = MODE_UCS2;
                    end
                end
            end
            4'hF: begin
                if (!dcs[2]) begin
                    m = MODE_GSM7;
                end
            end
            default: m = MODE_UNKNOWN;
        endcase
        return m;
    endfunction

    // number of utf-8 bytes of a token, 1 to 3
    function automatic logic [1:0] token_len(input t_token t);
        logic [1:0] n;
        if (t.raw || t.value < Utf8Two) begin
            n = 2'd1;
        end else if (t.value < Utf8Three) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ussd_front.sv -----
// front end: classifies the coding scheme, unpacks septets and pairs, emits character tokens
`default_nettype none

module ussd_front import ussd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_full,
    output t_push           o_push
);

    logic [7:0]  r_dcs;
    logic [13:0] r_buf, n_buf;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_esc, n_esc;
    logic [7:0]  r_high, n_high;
    logic        r_pair, n_pair;
    logic        r_ended, n_ended;
    logic        r_hold_valid, n_hold_valid;
    t_token      r_hold, n_hold;

    t_mode       w_mode;
    logic        w_accept;
    logic [13:0] w_buf;
    logic        w_two;
    logic [6:0]  w_c1, w_c2;
    logic        w_e1, w_e2, w_esc1, w_esc2, w_raw1;
    logic [15:0] w_v1, w_v2;

    assign w_mode   = classify(r_dcs);
    assign o_ready  = !r_hold_valid && !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_buf    = r_buf | (14'(i_byte) << r_cnt);
    assign w_two    = (r_cnt == 3'd6);
    assign w_c1     = w_buf[6:0];
    assign w_c2     = w_buf[13:7];

    always_comb begin
        w_e1   = 1'b0;
        w_e2   = 1'b0;
        w_v1   = 16'd0;
        w_v2   = 16'd0;
        w_esc1 = 1'b0;
        w_esc2 = 1'b0;
        w_raw1 = 1'b0;
        unique case (w_mode)
            MODE_GSM7: begin
                if (r_esc) begin
                    w_e1 = 1'b1;
                    w_v1 = extend_map(w_c1);
                end else if (w_c1 == EscSeptet) begin
                    w_esc1 = 1'b1;
                end else begin
                    w_e1 = 1'b1;
                    w_v1 = basic_map(w_c1);
                end
                w_esc2 = w_esc1;
                if (w_two) begin
                    w_esc2 = 1'b0;
                    if (w_esc1) begin
                        w_e2 = 1'b1;
                        w_v2 = extend_map(w_c2);
                    end else if (w_c2 == EscSeptet) begin
                        w_esc2 = 1'b1;
                    end else begin
                        w_e2 = 1'b1;
                        w_v2 = basic_map(w_c2);
                    end
                end
            end
            MODE_UCS2: begin
                w_e1 = r_pair;
                w_v1 = {r_high, i_byte};
            end
            default: begin
                w_e1   = !r_ended && (i_byte != 8'd0);
                w_v1   = {8'd0, i_byte};
                w_raw1 = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_esc        = r_esc;
        n_high       = r_high;
        n_pair       = r_pair;
        n_ended      = r_ended;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        o_push       = '0;
        if (r_hold_valid) begin
            if (!i_full) begin
                o_push.valid = 1'b1;
                o_push.tok   = r_hold;
                n_hold_valid = 1'b0;
            end
        end else if (w_accept) begin
            if (w_e1) begin
                o_push.valid      = 1'b1;
                o_push.tok.value  = w_v1;
                o_push.tok.raw    = w_raw1;
                o_push.tok.last   = !w_e2;
            end else if (w_e2) begin
                o_push.valid      = 1'b1;
                o_push.tok.value  = w_v2;
                o_push.tok.last   = 1'b1;
            end
            if (w_e1 && w_e2) begin
                n_hold_valid = 1'b1;
                n_hold.value = w_v2;
                n_hold.raw   = 1'b0;
                n_hold.last  = 1'b1;
            end
            unique case (w_mode)
                MODE_GSM7: begin
                    n_esc = w_esc2;
                    if (w_two) begin
                        n_buf = 14'd0;
                        n_cnt = 3'd0;
                    end else begin
                        n_buf = {7'd0, w_c2};
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                MODE_UCS2: begin
                    n_pair = !r_pair;
                    n_high = r_pair ? 8'd0 : i_byte;
                end
                default: begin
                    if (i_byte == 8'd0) begin
                        n_ended = 1'b1;
                    end
                end
            endcase
            if (i_last) begin
                n_buf   = 14'd0;
                n_cnt   = 3'd0;
                n_esc   = 1'b0;
                n_high  = 8'd0;
                n_pair  = 1'b0;
                n_ended = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcs        <= 8'h0F;
            r_buf        <= '0;
            r_cnt        <= '0;
            r_esc        <= 1'b0;
            r_high       <= '0;
            r_pair       <= 1'b0;
            r_ended      <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dcs <= i_cfg_wdata;
            end
            r_buf        <= n_buf;
            r_cnt        <= n_cnt;
            r_esc        <= n_esc;
            r_high       <= n_high;
            r_pair       <= n_pair;
            r_ended      <= n_ended;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> (r_cnt == 3'd0 && !r_esc && !r_pair && !r_ended))
        else $error("message state not cleared after last beat");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 3'd7)
        else $error("septet bit count out of range");

endmodule

`default_nettype wire

// ----- hdl/ussd_fifo.sv -----
// short token queue between the front end and the utf-8 back end
`default_nettype none

module ussd_fifo import ussd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_token     o_head
);

    t_token                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wr, r_rd;
    logic [QueueCntW-1:0]   r_cnt;
    logic                   w_wr, w_rd;

    assign o_full  = (r_cnt == QueueCntW'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
        return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_push.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (w_rd) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_full))
        else $error("token pushed into a full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QueueCntW'(QueueDepth))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- hdl/ussd_back.sv -----
// back end: expands queued tokens into utf-8 bytes through the output register
`default_nettype none

module ussd_back import ussd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_token     i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic [1:0] r_idx;
    logic [1:0] w_len;
    logic       w_load, w_end;

    assign w_len   = token_len(i_head);
    assign w_load  = !i_empty && (!r_valid || i_ready);
    assign w_end   = (r_idx == w_len - 2'd1);
    assign o_pop   = w_load && w_end;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign n_last  = i_head.last && w_end;

    always_comb begin
        n_byte = i_head.value[7:0];
        unique case (w_len)
            2'd2: begin
                if (r_idx == 2'd0) begin
                    n_byte = {3'b110, i_head.value[10:6]};
                end else begin
                    n_byte = {2'b10, i_head.value[5:0]};
                end
            end
            2'd3: begin
                unique case (r_idx)
                    2'd0:    n_byte = {4'b1110, i_head.value[15:12]};
                    2'd1:    n_byte = {2'b10, i_head.value[11:6]};
                    default: n_byte = {2'b10, i_head.value[5:0]};
                endcase
            end
            default: n_byte = i_head.value[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("utf-8 byte index out of range");

    a_idx_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> (!i_empty && r_idx < w_len))
        else $error("byte index points past the current token");

endmodule

`default_nettype wire

// ----- hdl/ussd_payload_to_utf8_decoder.sv -----
// top level of the ussd payload to utf-8 decoder
// Takes one payload byte per input beat and returns its text as UTF-8, one byte per output
// beat, with tlast on the final byte caused by each input beat (a beat that yields no text
// yields no output). The coding scheme byte written through i_cfg_we/i_cfg_wdata (reset 0x0F)
// selects GSM 7-bit, UCS2 or plain byte copy; write it only while the block is idle. An input
// beat with tlast ends the message and clears all unpacking state. Input beats are taken one per
// cycle while the four-entry character queue has room; a GSM 7-bit byte that completes two
// characters holds the input while its second character waits in the hold register. The output
// register gives one UTF-8 byte per cycle while the output is ready; a character takes one to
// three UTF-8 bytes, so the output side sets the sustained rate.
`default_nettype none

module ussd_payload_to_utf8_decoder import ussd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast
);

    t_push  w_push;
    logic   w_full;
    logic   w_empty;
    logic   w_pop;
    t_token w_head;

    ussd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_full      (w_full),
        .o_push      (w_push)
    );

    ussd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    ussd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- test/ussd_payload_to_utf8_decoder_tb.sv -----
// self-checking testbench of the ussd payload to utf-8 decoder with a built-in utf-8 predictor
`default_nettype none

module ussd_payload_to_utf8_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ussd_pkg::*;

    localparam int IdleWait  = 16;
    localparam int EndWait   = 32;
    localparam int HangLimit = 2000;
    localparam int BeatGoal  = 130;

    localparam logic [6:0] EscCode    = 7'h1B;
    localparam logic [7:0] CopyScheme = 8'hF4;

    localparam logic [15:0] Gsm7Basic [128] = '{
        16'h040, 16'h0A3, 16'h024, 16'h0A5, 16'h0E8, 16'h0E9, 16'h0F9, 16'h0EC,
        16'h0F2, 16'h0C7, 16'h00A, 16'h0D8, 16'h0F8, 16'h00D, 16'h0C5, 16'h0E5,
        16'h394, 16'h05F, 16'h3A6, 16'h393, 16'h39B, 16'h3A9, 16'h3A0, 16'h3A8,
        16'h3A3, 16'h398, 16'h39E, 16'h000, 16'h0C6, 16'h0E6, 16'h0DF, 16'h0C9,
        16'h020, 16'h021, 16'h022, 16'h023, 16'h0A4, 16'h025, 16'h026, 16'h027,
        16'h028, 16'h029, 16'h02A, 16'h02B, 16'h02C, 16'h02D, 16'h02E, 16'h02F,
        16'h030, 16'h031, 16'h032, 16'h033, 16'h034, 16'h035, 16'h036, 16'h037,
        16'h038, 16'h039, 16'h03A, 16'h03B, 16'h03C, 16'h03D, 16'h03E, 16'h03F,
        16'h0A1, 16'h041, 16'h042, 16'h043, 16'h044, 16'h045, 16'h046, 16'h047,
        16'h048, 16'h049, 16'h04A, 16'h04B, 16'h04C, 16'h04D, 16'h04E, 16'h04F,
        16'h050, 16'h051, 16'h052, 16'h053, 16'h054, 16'h055, 16'h056, 16'h057,
        16'h058, 16'h059, 16'h05A, 16'h0C4, 16'h0D6, 16'h0D1, 16'h0DC, 16'h0A7,
        16'h0BF, 16'h061, 16'h062, 16'h063, 16'h064, 16'h065, 16'h066, 16'h067,
        16'h068, 16'h069, 16'h06A, 16'h06B, 16'h06C, 16'h06D, 16'h06E, 16'h06F,
        16'h070, 16'h071, 16'h072, 16'h073, 16'h074, 16'h075, 16'h076, 16'h077,
        16'h078, 16'h079, 16'h07A, 16'h0E4, 16'h0F6, 16'h0F1, 16'h0FC, 16'h0E0
    };

    localparam logic [6:0] ExtKeys [10] = '{
        7'h0A, 7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, 7'h65
    };

    // euro, unmapped extension, 0x5d, escape after escape, escape left at end
    localparam logic [6:0] DirSeptets [10] = '{
        7'h1B, 7'h65, 7'h1B, 7'h00, 7'h5D, 7'h1B, 7'h1B, 7'h41, 7'h7F, 7'h1B
    };
    localparam logic [7:0] DirUcs2 [11] = '{
        8'h00, 8'h41, 8'hFF, 8'hFF, 8'hD8, 8'h3D, 8'h07, 8'hFF, 8'h00, 8'h00, 8'h20
    };
    localparam logic [7:0] DirCopy [5] = '{8'h41, 8'hFF, 8'h00, 8'h42, 8'h43};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] gap;
    } t_payload_beat;

    typedef struct packed {
        logic [7:0] utf8;
        logic       run_last;
    } t_utf8_beat;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [7:0] cfg_wdata  = 8'h00;
    logic       in_tvalid  = 1'b0;
    logic [7:0] in_tdata   = 8'h00;
    logic       in_tlast   = 1'b0;
    logic       out_tready = 1'b0;
    logic       in_tready;
    logic       out_tvalid;
    logic [7:0] out_tdata;
    logic       out_tlast;

    t_payload_beat pending_beats [$];
    t_payload_beat next_beat;
    t_utf8_beat    expected_utf8 [$];
    t_utf8_beat    got_want;
    logic [7:0]    text_bytes [$];

    int          queued_beats = 0;
    int          taken_beats  = 0;
    int          mismatches   = 0;
    int          hang_cycles  = 0;
    int unsigned tx_gap_max   = 0;
    int unsigned rx_stall_max = 0;
    int unsigned tx_wait      = 0;
    int unsigned rx_wait      = 0;
    int unsigned rx_stall;

    // predictor state
    logic [7:0]  dcs_reg   = 8'h0F;
    logic [13:0] sep_bits  = '0;
    logic [3:0]  sep_cnt   = '0;
    logic        esc_pend  = 1'b0;
    logic [7:0]  ucs_hi    = '0;
    logic        ucs_phase = 1'b0;
    logic        copy_done = 1'b0;

    // septet packer of the stimulus
    logic [15:0] pk_bits = '0;
    int          pk_cnt  = 0;
    logic        pk_have = 1'b0;
    logic [7:0]  pk_byte = '0;

    ussd_payload_to_utf8_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tlast  (in_tlast),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tlast  (out_tlast)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic t_mode scheme_mode(input logic [7:0] dcs);
        t_mode m;
        m = MODE_UNKNOWN;
        case (dcs[7:4])
            4'h0, 4'h2, 4'h3: m = MODE_GSM7;
            4'h1: begin
                if (dcs == DcsGsm7) begin
                    m = MODE_GSM7;
                end else if (dcs == DcsUcs2) begin
                    m = MODE_UCS2;
                end
            end
            4'h4, 4'h5, 4'h6, 4'h7: begin
                if (!dcs[5] && dcs[3:2] == 2'd0) begin
                    m = MODE_GSM7;
                end else if (!dcs[5] && dcs[3:2] == 2'd2) begin
                    m = MODE_UCS2;
                end
            end
            4'hF: begin
                if (!dcs[2]) begin
                    m = MODE_GSM7;
                end
            end
            default: m = MODE_UNKNOWN;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] gsm_extension_char(input logic [6:0] c);
        logic [15:0] v;
        case (c)
            7'h0A:   v = 16'h000C;
            7'h14:   v = 16'h005E;
            7'h28:   v = 16'h007B;
            7'h29:   v = 16'h007D;
            7'h2F:   v = 16'h005C;
            7'h3C:   v = 16'h005B;
            7'h3D:   v = 16'h007E;
            7'h3E:   v = 16'h005D;
            7'h40:   v = 16'h007C;
            7'h65:   v = 16'h20AC;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    task automatic add_code_point(input logic [15:0] v);
        if (v < 16'h0080) begin
            text_bytes.push_back(v[7:0]);
        end else if (v < 16'h0800) begin
            text_bytes.push_back({3'b110, v[10:6]});
            text_bytes.push_back({2'b10, v[5:0]});
        end else begin
            text_bytes.push_back({4'b1110, v[15:12]});
            text_bytes.push_back({2'b10, v[11:6]});
            text_bytes.push_back({2'b10, v[5:0]});
        end
    endtask

    task automatic predict_utf8(input logic [7:0] b, input logic last);
        logic [31:0] acc;
        logic [6:0]  sep;
        t_utf8_beat  r;
        text_bytes.delete();
        case (scheme_mode(dcs_reg))
            MODE_GSM7: begin
                acc = {18'd0, sep_bits} | ({24'd0, b} << sep_cnt);
                sep_bits = acc[13:0];
                sep_cnt = sep_cnt + 4'd8;
                while (sep_cnt >= 4'd7) begin
                    sep = sep_bits[6:0];
                    sep_bits = sep_bits >> 7;
                    sep_cnt = sep_cnt - 4'd7;
                    if (esc_pend) begin
                        esc_pend = 1'b0;
                        add_code_point(gsm_extension_char(sep));
                    end else if (sep == EscCode) begin
                        esc_pend = 1'b1;
                    end else begin
                        add_code_point(Gsm7Basic[sep]);
                    end
                end
            end
            MODE_UCS2: begin
                if (ucs_phase) begin
                    add_code_point({ucs_hi, b});
                    ucs_phase = 1'b0;
                    ucs_hi = '0;
                end else begin
                    ucs_hi = b;
                    ucs_phase = 1'b1;
                end
            end
            default: begin
                if (!copy_done) begin
                    if (b == 8'h00) begin
                        copy_done = 1'b1;
                    end else begin
                        text_bytes.push_back(b);
                    end
                end
            end
        endcase
        for (int i = 0; i < text_bytes.size(); i++) begin
            r.utf8 = text_bytes[i];
            r.run_last = (i == text_bytes.size() - 1);
            expected_utf8.push_back(r);
        end
        if (last) begin
            sep_bits = '0;
            sep_cnt = '0;
            esc_pend = 1'b0;
            ucs_hi = '0;
            ucs_phase = 1'b0;
            copy_done = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic last);
        t_payload_beat p;
        p.data = b;
        p.last = last;
        p.gap = 3'($urandom_range(0, tx_gap_max));
        pending_beats.push_back(p);
        queued_beats++;
    endtask

    // one byte is held back so the closing byte can carry tlast
    task automatic add_septet(input logic [6:0] s);
        pk_bits = pk_bits | ({9'd0, s} << pk_cnt);
        pk_cnt = pk_cnt + 7;
        if (pk_cnt >= 8) begin
            if (pk_have) begin
                queue_beat(pk_byte, 1'b0);
            end
            pk_byte = pk_bits[7:0];
            pk_have = 1'b1;
            pk_bits = pk_bits >> 8;
            pk_cnt = pk_cnt - 8;
        end
    endtask

    task automatic end_septets(input logic last);
        if (pk_cnt > 0) begin
            if (pk_have) begin
                queue_beat(pk_byte, 1'b0);
            end
            pk_byte = pk_bits[7:0];
            pk_have = 1'b1;
        end
        if (pk_have) begin
            queue_beat(pk_byte, last);
        end
        pk_bits = '0;
        pk_cnt = 0;
        pk_have = 1'b0;
    endtask

    task automatic wait_drained();
        while (taken_beats != queued_beats || expected_utf8.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_scheme(input logic [7:0] v);
        wait_drained();
        repeat (IdleWait) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        dcs_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic gen_message(input t_mode m, input logic close);
        int         n;
        logic       esc;
        logic [6:0] s;
        logic [7:0] hi;
        esc = 1'b0;
        if ($urandom_range(0, 6) == 0) begin
            // noise: raw bytes whatever the mode, stray message ends
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                queue_beat(8'($urandom_range(0, 255)),
                           (i == n - 1) ? close : ($urandom_range(0, 7) == 0));
            end
        end else begin
            case (m)
                MODE_GSM7: begin
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++) begin
                        if (esc && $urandom_range(0, 1) == 0) begin
                            s = ExtKeys[$urandom_range(0, 9)];
                        end else if ($urandom_range(0, 4) == 0) begin
                            s = EscCode;
                        end else begin
                            s = 7'($urandom_range(0, 127));
                        end
                        esc = !esc && (s == EscCode);
                        add_septet(s);
                    end
                    end_septets(close);
                end
                MODE_UCS2: begin
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++) begin
                        case ($urandom_range(0, 2))
                            0:       hi = 8'h00;
                            1:       hi = 8'($urandom_range(1, 7));
                            default: hi = 8'($urandom_range(0, 255));
                        endcase
                        queue_beat(hi, 1'b0);
                        queue_beat(8'($urandom_range(0, 255)), close && i == n - 1);
                    end
                end
                default: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        queue_beat(($urandom_range(0, 15) == 0) ? 8'h00
                                                                : 8'($urandom_range(1, 255)),
                                   close && i == n - 1);
                    end
                end
            endcase
        end
    endtask

    // driver: per-beat gap before presenting each payload byte
    always @(posedge clk) begin
        if (!rst_n) begin
            in_tvalid <= 1'b0;
            tx_wait <= 0;
        end else if (!in_tvalid || in_tready) begin
            if (pending_beats.size() == 0) begin
                in_tvalid <= 1'b0;
            end else begin
                next_beat = pending_beats[0];
                if (tx_wait < next_beat.gap) begin
                    in_tvalid <= 1'b0;
                    tx_wait <= tx_wait + 1;
                end else begin
                    in_tdata <= next_beat.data;
                    in_tlast <= next_beat.last;
                    in_tvalid <= 1'b1;
                    tx_wait <= 0;
                    next_beat = pending_beats.pop_front();
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_tvalid && in_tready) begin
            predict_utf8(in_tdata, in_tlast);
            taken_beats++;
        end
    end

    // monitor: checks each utf-8 beat, then draws a stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_tready <= 1'b0;
            rx_wait <= 0;
        end else if (out_tvalid && out_tready) begin
            if (expected_utf8.size() == 0) begin
                report_mismatch($sformatf("unexpected utf-8 byte %02h", out_tdata));
            end else begin
                got_want = expected_utf8.pop_front();
                if (out_tdata !== got_want.utf8) begin
                    report_mismatch($sformatf("utf-8 byte %02h, want %02h",
                                              out_tdata, got_want.utf8));
                end
                if (out_tlast !== got_want.run_last) begin
                    report_mismatch($sformatf("tlast %b on byte %02h, want %b",
                                              out_tlast, out_tdata, got_want.run_last));
                end
            end
            rx_stall = $urandom_range(0, rx_stall_max);
            if (rx_stall == 0) begin
                out_tready <= 1'b1;
            end else begin
                out_tready <= 1'b0;
                rx_wait <= rx_stall - 1;
            end
        end else if (!out_tready) begin
            if (rx_wait == 0) begin
                out_tready <= 1'b1;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
        if (hang_cycles >= HangLimit) begin
            $display("%0t no beat moved for %0d cycles", $realtime, HangLimit);
            $display("FAIL ussd_payload_to_utf8_decoder");
            $finish;
        end
    end

    initial begin
        logic [7:0] scheme;
        int         phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // gsm7 under the reset coding scheme
        for (int i = 0; i < 10; i++) begin
            add_septet(DirSeptets[i]);
        end
        end_septets(1'b1);

        write_scheme(DcsUcs2);
        tx_gap_max = 7;
        rx_stall_max = 7;
        for (int i = 0; i < 11; i++) begin
            queue_beat(DirUcs2[i], i == 10);
        end

        write_scheme(CopyScheme);
        tx_gap_max = 0;
        for (int i = 0; i < 5; i++) begin
            queue_beat(DirCopy[i], i == 4);
        end

        phase = 0;
        while (queued_beats < BeatGoal) begin
            case (phase)
                0:       scheme = 8'h00;
                1:       scheme = 8'hFF;
                2:       scheme = 8'h11;
                3:       scheme = 8'h48;
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        scheme = {3'b010, 1'($urandom_range(0, 1)), 2'b10,
                                  2'($urandom_range(0, 3))};
                    end else begin
                        scheme = 8'($urandom_range(0, 255));
                    end
                end
            endcase
            write_scheme(scheme);
            tx_gap_max = ($urandom_range(0, 1) == 0) ? 0 : 7;
            rx_stall_max = ($urandom_range(0, 1) == 0) ? 0 : 7;
            // the last message of a phase may stay open across the scheme change
            for (int m = 0; m < 3; m++) begin
                gen_message(scheme_mode(scheme), m < 2 || $urandom_range(0, 2) != 0);
            end
            phase++;
        end

        wait_drained();
        repeat (EndWait) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS ussd_payload_to_utf8_decoder");
        end else begin
            $display("FAIL ussd_payload_to_utf8_decoder");
        end
        $finish;
    end

endmodule

`default_nettype wire
